FILE: hdl/pts_pkg.sv
package pts_pkg;

	localparam int unsigned MaxNest   = 255;
	localparam int unsigned LenCap    = 65535;
	localparam int unsigned NestW     = 8;
	localparam int unsigned LenW      = 16;
	localparam int unsigned PosW      = 32;
	localparam int unsigned RadixLim  = 36;

	typedef enum logic [3:0] {
		M_IDLE, M_DOCCHK, M_CMT, M_DOCTYPE, M_SLASH, M_LIT, M_IMM, M_OPER,
		M_NUM, M_ANGLE, M_STR, M_HEX, M_A85, M_DICT, M_ARRAY, M_PROC
	} mode_t;

	typedef enum logic [3:0] {
		S_NONE, S_STR, S_ESC, S_CMT, S_LT, S_GT, S_HEX, S_A85, S_A85T
	} sub_t;

	localparam logic [3:0] K_INT = 4'd0, K_REAL = 4'd1, K_LIT = 4'd2, K_IMM = 4'd3,
		K_STR = 4'd4, K_HEX = 4'd5, K_A85 = 4'd6, K_DICT = 4'd7, K_ARRAY = 4'd8,
		K_PROC = 4'd9, K_OPER = 4'd10, K_DOC = 4'd11;

	localparam logic [1:0] ST_OK = 2'd0, ST_HEX = 2'd1, ST_A85 = 2'd2, ST_NEST = 2'd3;

	// scanner state carried between bytes
	typedef struct packed {
		mode_t             mode;
		logic [3:0]        num;
		logic [NestW-1:0]  nest;
		logic [NestW-1:0]  paren;
		sub_t              sub;
		logic              first;
		logic [PosW-1:0]   pos;
		logic [PosW-1:0]   start;
		logic [LenW-1:0]   len;
	} scan_t;

	// one finished token
	typedef struct packed {
		logic              valid;
		logic [3:0]        kind;
		logic [1:0]        status;
		logic [PosW-1:0]   start;
		logic [LenW-1:0]   len;
	} tok_t;

	function automatic logic [3:0] mode_kind(mode_t m);
		logic [3:0] k;
		case (m)
			M_DOCCHK, M_CMT, M_DOCTYPE: k = K_DOC;
			M_SLASH, M_LIT:             k = K_LIT;
			M_IMM:                      k = K_IMM;
			M_ANGLE, M_HEX:             k = K_HEX;
			M_STR:                      k = K_STR;
			M_A85:                      k = K_A85;
			M_DICT:                     k = K_DICT;
			M_ARRAY:                    k = K_ARRAY;
			M_PROC:                     k = K_PROC;
			default:                    k = K_OPER;
		endcase
		return k;
	endfunction

endpackage

FILE: hdl/pts_step.sv
// Next-state and token logic for one source byte
module pts_step (
	input  pts_pkg::scan_t cur,
	input  logic [7:0]     c,
	input  logic           restart,
	output pts_pkg::scan_t nxt,
	output pts_pkg::tok_t  tok
);
	import pts_pkg::*;

	scan_t s;
	scan_t n;
	logic  white, nl, delim, dig;
	logic [6:0] dval;
	logic  do_emit, do_start, cont, done_c;
	logic [3:0] ekind;
	logic [1:0] estat;
	logic [3:0] nn;
	logic  ex, sg;
	logic  reproc;
	logic [7:0] opn, cls;

	always_comb begin
		white = (c == 8'd0) || (c == 8'd9) || (c == 8'd10) || (c == 8'd12) ||
			(c == 8'd13) || (c == 8'd32);
		nl = (c == 8'd10) || (c == 8'd13);
		delim = white || c == "(" || c == ")" || c == "<" || c == ">" || c == "[" ||
			c == "]" || c == "{" || c == "}" || c == "/" || c == "%";
		if (c >= "0" && c <= "9") dval = 7'(c - 8'h30);
		else if (c >= "A" && c <= "Z") dval = 7'(c - 8'h41) + 7'd10;
		else if (c >= "a" && c <= "z") dval = 7'(c - 8'h61) + 7'd10;
		else dval = 7'd99;
		dig = dval < 7'd10;
		ex = c == "E" || c == "e";
		sg = c == "+" || c == "-";
		case (cur.num)
			4'd1: nn = dig ? 4'd1 : c == "." ? 4'd4 : c == "#" ? 4'd5 : 4'd0;
			4'd2: nn = dig ? 4'd6 : c == "." ? 4'd3 : 4'd0;
			4'd3: nn = dig ? 4'd7 : 4'd0;
			4'd4, 4'd7: nn = dig ? 4'd7 : ex ? 4'd8 : 4'd0;
			4'd5, 4'd9: nn = (dval < 7'(RadixLim)) ? 4'd9 : 4'd0;
			4'd6: nn = dig ? 4'd6 : c == "." ? 4'd7 : 4'd0;
			4'd8: nn = dig ? 4'd10 : sg ? 4'd11 : 4'd0;
			4'd10, 4'd11: nn = dig ? 4'd10 : 4'd0;
			default: nn = 4'd0;
		endcase
	end

	always_comb begin
		s = cur;
		if (restart) begin
			s.mode = M_IDLE; s.num = '0; s.nest = '0; s.paren = '0; s.sub = S_NONE;
			s.first = 1'b1; s.pos = '0; s.start = '0; s.len = '0;
		end
		n = s;
		do_emit = 1'b0;
		do_start = 1'b0;
		cont = 1'b0;
		done_c = 1'b0;
		ekind = mode_kind(s.mode);
		estat = ST_OK;
		reproc = 1'b0;
		opn = (s.mode == M_PROC) ? "{" : "[";
		cls = (s.mode == M_PROC) ? "}" : "]";
		case (s.mode)
			M_IDLE: do_start = 1'b1;
			M_DOCCHK: begin
				if (c == "!") begin
					n.mode = M_DOCTYPE;
					if (s.len < LenW'(LenCap)) n.len = s.len + 1'b1;
				end else n.mode = nl ? M_IDLE : M_CMT;
			end
			M_CMT: if (nl) n.mode = M_IDLE;
			M_DOCTYPE: begin
				if (nl) do_emit = 1'b1;
				else if (s.len < LenW'(LenCap)) n.len = s.len + 1'b1;
			end
			M_SLASH, M_LIT, M_IMM, M_OPER, M_NUM: begin
				if (delim && !(s.mode == M_SLASH && c == "/")) begin
					do_emit = 1'b1;
					do_start = 1'b1;
					if (s.mode == M_NUM)
						ekind = (s.num == 4'd1 || s.num == 4'd6 || s.num == 4'd9) ? K_INT :
							(s.num == 4'd4 || s.num == 4'd7 || s.num == 4'd10) ? K_REAL : K_OPER;
				end else begin
					if (s.len < LenW'(LenCap)) n.len = s.len + 1'b1;
					if (s.mode == M_SLASH) n.mode = (c == "/") ? M_IMM : M_LIT;
					if (s.mode == M_NUM) begin
						n.num = nn;
						if (nn == 4'd0) n.mode = M_OPER;
					end
				end
			end
			default: begin
				cont = 1'b1;
				if (s.len < LenW'(LenCap)) n.len = s.len + 1'b1;
				// lookahead subs S_LT / S_GT fall through to a second pass on other bytes
				case (s.sub)
					S_STR: begin
						if (c == "\\") n.sub = S_ESC;
						else if (c == "(") begin
							if (s.paren >= NestW'(MaxNest)) begin done_c = 1'b1; estat = ST_NEST; end
							else n.paren = s.paren + 1'b1;
						end else if (c == ")") begin
							if (s.paren <= NestW'(1)) begin
								n.paren = '0; n.sub = S_NONE;
								if (s.mode == M_STR) done_c = 1'b1;
							end else n.paren = s.paren - 1'b1;
						end
					end
					S_ESC: n.sub = S_STR;
					S_CMT: if (nl) n.sub = S_NONE;
					S_HEX: reproc = 1'b1;
					S_A85: begin
						if (c == "~") n.sub = S_A85T;
						else if ((c < "!" || c > "u") && !white && c != "z") begin
							done_c = 1'b1; estat = ST_A85;
						end
					end
					S_A85T: begin
						if (c != ">") begin done_c = 1'b1; estat = ST_A85; end
						else begin
							n.sub = S_NONE;
							if (s.mode == M_A85) done_c = 1'b1;
						end
					end
					S_LT: begin
						if (c == "<") begin
							n.sub = S_NONE;
							if (s.mode == M_ANGLE) begin n.mode = M_DICT; n.nest = NestW'(1); end
							else if (s.nest >= NestW'(MaxNest)) begin
								done_c = 1'b1; estat = ST_NEST;
							end else n.nest = s.nest + 1'b1;
						end else if (c == "~") begin
							if (s.mode == M_ANGLE) n.mode = M_A85;
							n.sub = S_A85;
						end else begin
							if (s.mode == M_ANGLE) n.mode = M_HEX;
							n.sub = S_HEX;
							reproc = 1'b1;
						end
					end
					S_GT: begin
						n.sub = S_NONE;
						if (c == ">") begin
							n.nest = (s.nest != '0) ? s.nest - 1'b1 : s.nest;
							if (s.nest <= NestW'(1)) done_c = 1'b1;
						end else reproc = 1'b1;
					end
					default: reproc = 1'b1;
				endcase
				// second pass: hex byte, plain byte, or byte after a lone '>' in a dict
				if (reproc) begin
					if (n.sub == S_HEX) begin
						if (c == ">") begin
							n.sub = S_NONE;
							if (n.mode == M_HEX) done_c = 1'b1;
						end else if (dval >= 7'd16 && !white) begin
							done_c = 1'b1; estat = ST_HEX;
						end
					end else begin
						n.sub = S_NONE;
						if (c == "%") n.sub = S_CMT;
						else if (c == "(") begin n.sub = S_STR; n.paren = NestW'(1); end
						else if (n.mode == M_DICT) begin
							if (c == "<") n.sub = S_LT;
							else if (c == ">") n.sub = S_GT;
						end else if (c == opn) begin
							if (n.nest >= NestW'(MaxNest)) begin done_c = 1'b1; estat = ST_NEST; end
							else n.nest = n.nest + 1'b1;
						end else if (c == cls) begin
							if (n.nest <= NestW'(1)) begin n.nest = '0; done_c = 1'b1; end
							else n.nest = n.nest - 1'b1;
						end
					end
				end
				if (done_c) begin
					do_emit = 1'b1;
					ekind = mode_kind(n.mode);
				end
			end
		endcase
		tok.valid  = do_emit;
		tok.kind   = ekind;
		tok.status = estat;
		tok.start  = s.start;
		tok.len    = cont ? n.len : s.len;
		if (do_emit) begin
			n.mode = M_IDLE; n.num = '0; n.nest = '0; n.paren = '0; n.sub = S_NONE;
		end
		// first byte of the next token
		if (do_start && !white) begin
			n.mode = M_OPER; n.num = '0; n.nest = '0; n.paren = '0; n.sub = S_NONE;
			n.start = s.pos;
			n.len = LenW'(1);
			if (c == "%") begin
				n.mode = s.first ? M_DOCCHK : M_CMT;
				n.first = 1'b0;
			end else if (c == "/") n.mode = M_SLASH;
			else if (c == "{") begin n.mode = M_PROC; n.nest = NestW'(1); end
			else if (c == "[") begin n.mode = M_ARRAY; n.nest = NestW'(1); end
			else if (c == "(") begin n.mode = M_STR; n.sub = S_STR; n.paren = NestW'(1); end
			else if (c == "<") begin n.mode = M_ANGLE; n.sub = S_LT; end
			else if (dig) begin n.mode = M_NUM; n.num = 4'd1; end
			else if (sg) begin n.mode = M_NUM; n.num = 4'd2; end
			else if (c == ".") begin n.mode = M_NUM; n.num = 4'd3; end
		end
		n.pos = s.pos + 1'b1;
		nxt = n;
	end

endmodule

FILE: hdl/postscript_token_scanner.sv
// channel | direction | tdata fields (low bit up)              | tuser
// s_axis  | in        | data_byte[7:0]                         | begin_stream
// m_axis  | out       | token_kind[3:0] status[5:4]            | -
//         |           | token_start[37:6] token_length[53:38]  |
// One byte per cycle while ready is high: a byte is scanned in the cycle it is
// accepted, the token lands in a one-entry output register the next cycle.
// Input is taken whenever the output register is empty or being drained in the
// same cycle. arst_n clears scanner state and empties the output register.
module postscript_token_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // begin_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata    // kind, status, start, length, 2 pad bits
);
	import pts_pkg::*;

	scan_t st_q, st_nx;
	tok_t  tk_nx;
	logic  ovld_q;
	logic [53:0] odat_q;
	logic  take;

	pts_step u_step (
		.cur(st_q), .c(s_axis_tdata), .restart(s_axis_tuser), .nxt(st_nx), .tok(tk_nx)
	);

	assign s_axis_tready = !ovld_q || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: M_IDLE, num: '0, nest: '0, paren: '0, sub: S_NONE,
				first: 1'b1, pos: '0, start: '0, len: '0};
		end else if (take) begin
			st_q <= st_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (take) begin
			ovld_q <= tk_nx.valid;
		end else if (m_axis_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && tk_nx.valid) odat_q <= {tk_nx.len, tk_nx.start, tk_nx.status, tk_nx.kind};
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = {2'b00, odat_q};

endmodule

FILE: hdl/pts_checker.sv
module pts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);
	// output holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	// free output slot always takes input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready) else $error("ready low with empty output");
	// no token appears without an input transfer
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |=> !m_axis_tvalid || $past(s_axis_tvalid && s_axis_tready))
		else $error("token without input");
	// kind is in range
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd11) else $error("bad kind");
endmodule

bind postscript_token_scanner pts_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
